[hdl/srt_pkg.sv]
// Shared types and constants for the selective resend tracker.
`default_nettype none

package srt_pkg;

    // Fixed field widths.
    localparam int ACTION_W  = 2;
    localparam int SEQ_W     = 10;
    localparam int COUNT_W   = 11;
    localparam int LENGTH_W  = 16;
    localparam int OFFSET_W  = 26;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Largest number of fragments that a sequence number can address.
    localparam int SEQ_SPAN = 1024;

    // Reset values of the configuration registers.
    localparam logic [COUNT_W-1:0]  FRAG_COUNT_RESET  = 11'd1;
    localparam logic [LENGTH_W-1:0] FRAG_LENGTH_RESET = 16'd1024;

    // Item actions.
    typedef enum logic [ACTION_W-1:0] {
        ACT_ACK     = 2'd0,
        ACT_SEND    = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAG_COUNT  = 2'd0,
        CFG_FRAG_LENGTH = 2'd1
    } cfg_index_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ACK,
        ST_SCAN,
        ST_RESTART,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic step;
        logic clear_wr;
        logic ack_check;
        logic scan_check;
        logic load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_word;
        logic ack_here;
        logic scan_done;
        logic in_bad;
    } dp_stat_t;

endpackage

`default_nettype wire

[hdl/srt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module srt_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/srt_ctrl.sv]
// Controller state machine of the selective resend tracker.
`default_nettype none

module srt_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [srt_pkg::ACTION_W-1:0]      action,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output srt_pkg::dp_cmd_t                       cmd,
    input  wire srt_pkg::dp_stat_t                 stat
);

    import srt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output register can take a result when empty or being emptied.
    assign out_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (stat.last_word)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (action_t'(action))
                        ACT_ACK:     state_next = stat.in_bad ? ST_DONE : ST_ACK;
                        ACT_SEND:    state_next = ST_SCAN;
                        ACT_RESTART: state_next = ST_RESTART;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_ACK:
            begin
                if (stat.ack_here)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RESTART:
            begin
                if (stat.last_word)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.clear_wr = 1'b1;
                cmd.step     = !stat.last_word;
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_ACK:
            begin
                cmd.ack_check = 1'b1;
                cmd.step      = !stat.ack_here;
            end
            ST_SCAN:
            begin
                cmd.scan_check = 1'b1;
                cmd.step       = !stat.scan_done;
            end
            ST_RESTART:
            begin
                cmd.clear_wr = 1'b1;
                cmd.step     = !stat.last_word;
            end
            ST_DONE:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Output valid flag: set on a load, cleared once the transfer completes.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A result is only loaded when the output register has room.
    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    // A restart item always runs the map sweep.
    a_restart_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && action == ACT_RESTART) |=> state_reg == ST_RESTART)
        else $error("restart did not start the map sweep");

    // A new result only appears after the finishing state.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result appeared outside the finishing state");

    // No item is taken while a scan or sweep is running.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_ACK || state_reg == ST_RESTART
         || state_reg == ST_INIT) |-> !in_ready)
        else $error("item taken while busy");

endmodule

`default_nettype wire

[hdl/srt_datapath.sv]
// Datapath of the selective resend tracker: map memory, scan logic and result registers.
`default_nettype none

module srt_datapath #(
    parameter int MAX_FRAGMENTS  = 1024,
    parameter int SCAN_WORD_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic [srt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [srt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [srt_pkg::ACTION_W-1:0]      action,
    input  wire logic [srt_pkg::SEQ_W-1:0]         ack_seq,
    input  wire srt_pkg::dp_cmd_t                  cmd,
    output srt_pkg::dp_stat_t                      stat,
    output logic                                   send_valid,
    output logic      [srt_pkg::SEQ_W-1:0]         send_seq,
    output logic      [srt_pkg::OFFSET_W-1:0]      send_offset,
    output logic                                   newly_delivered,
    output logic                                   bad_seq,
    output logic      [srt_pkg::COUNT_W-1:0]       delivered_total,
    output logic                                   all_delivered
);

    import srt_pkg::*;

    localparam int MAP_DEPTH = (MAX_FRAGMENTS < SEQ_SPAN) ? MAX_FRAGMENTS : SEQ_SPAN;
    localparam int NUM_WORDS = (MAP_DEPTH + SCAN_WORD_BITS - 1) / SCAN_WORD_BITS;
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = (SCAN_WORD_BITS > 1) ? $clog2(SCAN_WORD_BITS) : 1;
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);
    localparam logic [COUNT_W-1:0] WORD_STEP = COUNT_W'(SCAN_WORD_BITS);
    localparam logic [COUNT_W-1:0] MAP_LIMIT = COUNT_W'(MAP_DEPTH);

    // Configuration and tracking state.
    logic [COUNT_W-1:0]  frag_count_reg;
    logic [LENGTH_W-1:0] frag_len_reg;
    logic [COUNT_W-1:0]  counter_reg, counter_next;
    logic [SEQ_W-1:0]    cursor_reg, cursor_next;

    // Per-item working registers.
    logic [SEQ_W-1:0]    seq_reg, seq_next;
    logic [SEQ_W-1:0]    start_reg, start_next;
    logic [WORD_AW-1:0]  widx_reg, widx_next;
    logic [COUNT_W-1:0]  base_reg, base_next;
    logic                lo_found_reg, lo_found_next;
    logic [SEQ_W-1:0]    lo_seq_reg, lo_seq_next;
    logic                res_valid_reg, res_valid_next;
    logic [SEQ_W-1:0]    res_seq_reg, res_seq_next;
    logic                res_newly_reg, res_newly_next;
    logic                res_bad_reg, res_bad_next;

    // Output payload registers.
    logic                out_send_valid_reg;
    logic [SEQ_W-1:0]    out_send_seq_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic                out_newly_reg;
    logic                out_bad_reg;
    logic [COUNT_W-1:0]  out_total_reg;
    logic                out_all_reg;

    // Map memory signals.
    logic                      wr_en;
    logic [SCAN_WORD_BITS-1:0] wr_data;
    logic [SCAN_WORD_BITS-1:0] rd_data;

    // Scan and acknowledge helpers.
    logic [COUNT_W-1:0]        eff_count;
    logic [COUNT_W-1:0]        base_plus_w;
    logic [COUNT_W-1:0]        start_ext;
    logic [COUNT_W-1:0]        bit_idx [SCAN_WORD_BITS];
    logic [SCAN_WORD_BITS-1:0] hi_mask;
    logic [SCAN_WORD_BITS-1:0] lo_mask;
    logic                      hi_any;
    logic                      lo_any;
    logic [BIT_W-1:0]          hi_pos;
    logic [BIT_W-1:0]          lo_pos;
    logic [COUNT_W-1:0]        hi_seq;
    logic [COUNT_W-1:0]        lo_seq_now;
    logic                      scan_last;
    logic [COUNT_W-1:0]        ack_diff;
    logic [BIT_W-1:0]          ack_bit;
    logic [SCAN_WORD_BITS-1:0] ack_onehot;
    logic                      ack_here;
    logic                      ack_set;
    logic [COUNT_W-1:0]        cursor_inc;

    // Effective count saturates at the map size.
    assign eff_count   = (frag_count_reg > MAP_LIMIT) ? MAP_LIMIT : frag_count_reg;
    assign base_plus_w = base_reg + WORD_STEP;
    assign start_ext   = {1'b0, start_reg};
    assign scan_last   = (widx_reg == LAST_WORD) || (base_plus_w >= eff_count);

    // Mask the current word to the live range, split at the start point.
    always_comb
    begin
        for (int b = 0; b < SCAN_WORD_BITS; b++)
        begin
            bit_idx[b] = base_reg + COUNT_W'(b);
            hi_mask[b] = rd_data[b] && (bit_idx[b] < eff_count) && (bit_idx[b] >= start_ext);
            lo_mask[b] = rd_data[b] && (bit_idx[b] < eff_count) && (bit_idx[b] < start_ext);
        end
    end

    // Lowest set bit of each masked word.
    always_comb
    begin
        hi_any = 1'b0;
        lo_any = 1'b0;
        hi_pos = '0;
        lo_pos = '0;
        for (int b = SCAN_WORD_BITS - 1; b >= 0; b--)
        begin
            if (hi_mask[b])
            begin
                hi_any = 1'b1;
                hi_pos = BIT_W'(b);
            end
            if (lo_mask[b])
            begin
                lo_any = 1'b1;
                lo_pos = BIT_W'(b);
            end
        end
    end

    assign hi_seq     = base_reg + COUNT_W'(hi_pos);
    assign lo_seq_now = base_reg + COUNT_W'(lo_pos);

    // Acknowledge bit within the current word.
    assign ack_diff = {1'b0, seq_reg} - base_reg;
    assign ack_bit  = ack_diff[BIT_W-1:0];
    assign ack_here = {1'b0, seq_reg} < base_plus_w;
    assign ack_set  = rd_data[ack_bit];

    always_comb
    begin
        for (int b = 0; b < SCAN_WORD_BITS; b++)
        begin
            ack_onehot[b] = (ack_bit == BIT_W'(b));
        end
    end

    // Map writes: a sweep sets every word, an acknowledge clears one bit.
    assign wr_en   = cmd.clear_wr || (cmd.ack_check && ack_here && ack_set);
    assign wr_data = cmd.clear_wr ? {SCAN_WORD_BITS{1'b1}} : (rd_data & ~ack_onehot);

    assign cursor_inc = {1'b0, res_seq_reg} + COUNT_W'(1);

    // Next values of the working state.
    always_comb
    begin
        counter_next   = counter_reg;
        cursor_next    = cursor_reg;
        seq_next       = seq_reg;
        start_next     = start_reg;
        widx_next      = widx_reg;
        base_next      = base_reg;
        lo_found_next  = lo_found_reg;
        lo_seq_next    = lo_seq_reg;
        res_valid_next = res_valid_reg;
        res_seq_next   = res_seq_reg;
        res_newly_next = res_newly_reg;
        res_bad_next   = res_bad_reg;

        if (cmd.accept)
        begin
            seq_next       = ack_seq;
            start_next     = ({1'b0, cursor_reg} < eff_count) ? cursor_reg : '0;
            widx_next      = '0;
            base_next      = '0;
            lo_found_next  = 1'b0;
            res_valid_next = 1'b0;
            res_seq_next   = '0;
            res_newly_next = 1'b0;
            res_bad_next   = (action == ACT_ACK) && stat.in_bad;
            if (action == ACT_RESTART)
            begin
                counter_next = '0;
                cursor_next  = '0;
            end
        end
        else if (cmd.step)
        begin
            widx_next = widx_reg + WORD_AW'(1);
            base_next = base_plus_w;
        end

        // Acknowledge lands on this word.
        if (cmd.ack_check && ack_here && ack_set)
        begin
            counter_next   = counter_reg + COUNT_W'(1);
            res_newly_next = 1'b1;
        end

        // Scan: a hit at or after the start wins, else the lowest hit before it.
        if (cmd.scan_check)
        begin
            if (hi_any)
            begin
                res_valid_next = 1'b1;
                res_seq_next   = hi_seq[SEQ_W-1:0];
            end
            else if (scan_last)
            begin
                if (lo_found_reg)
                begin
                    res_valid_next = 1'b1;
                    res_seq_next   = lo_seq_reg;
                end
                else if (lo_any)
                begin
                    res_valid_next = 1'b1;
                    res_seq_next   = lo_seq_now[SEQ_W-1:0];
                end
            end
            else if (lo_any && !lo_found_reg)
            begin
                lo_found_next = 1'b1;
                lo_seq_next   = lo_seq_now[SEQ_W-1:0];
            end
        end

        // Cursor moves past the sent fragment once the result is loaded.
        if (cmd.load_out && res_valid_reg)
        begin
            cursor_next = (cursor_inc < eff_count) ? cursor_inc[SEQ_W-1:0] : '0;
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frag_count_reg <= FRAG_COUNT_RESET;
            frag_len_reg   <= FRAG_LENGTH_RESET;
            counter_reg    <= '0;
            cursor_reg     <= '0;
            widx_reg       <= '0;
            base_reg       <= '0;
            lo_found_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_FRAG_COUNT)
            begin
                frag_count_reg <= cfg_data[COUNT_W-1:0];
            end
            if (cfg_valid && cfg_index == CFG_FRAG_LENGTH)
            begin
                frag_len_reg <= cfg_data[LENGTH_W-1:0];
            end
            counter_reg   <= counter_next;
            cursor_reg    <= cursor_next;
            widx_reg      <= widx_next;
            base_reg      <= base_next;
            lo_found_reg  <= lo_found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        seq_reg       <= seq_next;
        start_reg     <= start_next;
        lo_seq_reg    <= lo_seq_next;
        res_seq_reg   <= res_seq_next;
        res_newly_reg <= res_newly_next;
        res_bad_reg   <= res_bad_next;
        if (cmd.load_out)
        begin
            out_send_valid_reg <= res_valid_reg;
            out_send_seq_reg   <= res_seq_reg;
            out_offset_reg     <= OFFSET_W'(res_seq_reg) * OFFSET_W'(frag_len_reg);
            out_newly_reg      <= res_newly_reg;
            out_bad_reg        <= res_bad_reg;
            out_total_reg      <= counter_reg;
            out_all_reg        <= (counter_reg == eff_count);
        end
    end

    // Outstanding map, one scan word per entry.
    srt_ram #(
        .WIDTH (SCAN_WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (widx_reg),
        .wr_data (wr_data),
        .rd_addr (widx_next),
        .rd_data (rd_data)
    );

    // Status to the controller.
    always_comb
    begin
        stat.last_word = (widx_reg == LAST_WORD);
        stat.ack_here  = ack_here;
        stat.scan_done = hi_any || scan_last;
        stat.in_bad    = ({1'b0, ack_seq} >= eff_count);
    end

    assign send_valid      = out_send_valid_reg;
    assign send_seq        = out_send_seq_reg;
    assign send_offset     = out_offset_reg;
    assign newly_delivered = out_newly_reg;
    assign bad_seq         = out_bad_reg;
    assign delivered_total = out_total_reg;
    assign all_delivered   = out_all_reg;

endmodule

`default_nettype wire

[hdl/selective_resend_tracker_core.sv]
// Top level of the selective resend tracker: controller and datapath.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+------------------------------------------------
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//  in       | in_valid / in_ready   | action, ack_seq
//  out      | out_valid / out_ready | send_valid, send_seq, send_offset,
//           |                       | newly_delivered, bad_seq, delivered_total,
//           |                       | all_delivered
//
// With W = SCAN_WORD_BITS and N = ceil(min(MAX_FRAGMENTS, 1024) / W) map words,
// the map memory is walked one word per cycle. A send request scans until a hit or
// the last word, an acknowledge walks to the word that holds ack_seq, a restart
// sweeps all N words, and an out-of-range acknowledge or any other action goes
// straight to the result. After reset the map is filled with ones before the first
// item transfer. A waiting result does not block the next item; only loading the
// following result waits for the output register to be taken.
`default_nettype none

module selective_resend_tracker_core #(
    parameter int MAX_FRAGMENTS  = 1024,
    parameter int SCAN_WORD_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [srt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [srt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [srt_pkg::ACTION_W-1:0]      action,
    input  wire logic [srt_pkg::SEQ_W-1:0]         ack_seq,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   send_valid,
    output logic      [srt_pkg::SEQ_W-1:0]         send_seq,
    output logic      [srt_pkg::OFFSET_W-1:0]      send_offset,
    output logic                                   newly_delivered,
    output logic                                   bad_seq,
    output logic      [srt_pkg::COUNT_W-1:0]       delivered_total,
    output logic                                   all_delivered
);

    import srt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    srt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    srt_datapath #(
        .MAX_FRAGMENTS  (MAX_FRAGMENTS),
        .SCAN_WORD_BITS (SCAN_WORD_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .action          (action),
        .ack_seq         (ack_seq),
        .cmd             (cmd),
        .stat            (stat),
        .send_valid      (send_valid),
        .send_seq        (send_seq),
        .send_offset     (send_offset),
        .newly_delivered (newly_delivered),
        .bad_seq         (bad_seq),
        .delivered_total (delivered_total),
        .all_delivered   (all_delivered)
    );

endmodule

`default_nettype wire
